[rtl/ordered_timer_table_defines.svh]
// Assertion macros used by the ordered_timer_table module.
`ifndef ORDERED_TIMER_TABLE_DEFINES_SVH
`define ORDERED_TIMER_TABLE_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define OTT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered_timer_table check failed");
// Assert that a condition implies a consequence in the next cycle.
`define OTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered_timer_table check failed");
`endif

[rtl/ott_pkg.sv]
package ott_pkg;
  localparam int unsigned HOUR_MS = 3600000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    K_ADD = 3'd0, K_CANCEL = 3'd1, K_REFRESH = 3'd2,
    K_RESET = 3'd3, K_QUERY = 3'd4, K_POLL = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NONE = 2'd1, ST_BUSY = 2'd2
  } status_t;

  // One slot as held in memory: rearm, interval, deadline.
  typedef struct packed {
    logic        rearm;
    logic [31:0] interval;
    logic [63:0] deadline;
  } slot_ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MOD, S_SCAN, S_SCANW, S_QOUT, S_FIRE, S_FIREW, S_OUT
  } state_t;
endpackage

[rtl/ott_ram.sv]
module ott_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/ordered_timer_table.sv]
// Deadline-ordered timer table. One request (add, cancel, refresh, reset,
// next query, expire poll) is handled at a time. A new request is taken only
// after the previous result has left the output register. Slot data lives in
// one RAM that is read one slot per cycle. Steps from the accepting edge to
// a valid result:
// - An unknown kind goes straight to output.
// - Cancel and refresh go through read, modify, output. So do an add to
//   a busy slot and a request to an idle slot.
// - An add, or a reset that moves a deadline, then scans every slot to find
//   the front.
// - A next query is one scan.
// - A poll scans once per fired slot and gives one result for each fired
//   slot. When nothing fires it makes one scan.
// Poll results come in deadline order, ties to the lower slot. Waiting on
// out_tready delays every result.
`include "ordered_timer_table_defines.svh"
module ordered_timer_table
  import ott_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // slot[3:0], period_ms[35:4], repeat_req[36], use_now[37], now_ms[101:38]
  input  logic [103:0] in_tdata,
  // kind[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], fired_valid[2], fired_slot[6:3], wait_ms[70:7],
  // front_notify[71], any_armed[72]
  output logic [79:0]  out_tdata,
  output logic         out_tlast
);
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  state_t state_r, state_nxt;
  logic [SLOTS-1:0] armed_r, armed_nxt;
  logic [SLOTS-1:0] done_r, done_nxt;    // fired already in this poll
  logic             notified_r, notified_nxt;
  logic [63:0]      prev_r, prev_nxt;

  logic [2:0]  kind_r, kind_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic [31:0] per_r, per_nxt;
  logic        rep_r, rep_nxt, fnow_r, fnow_nxt;
  logic [63:0] now_r, now_nxt;
  logic        jump_r, jump_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        fn_r, fn_nxt, chk_r, chk_nxt;
  logic        surv_r, surv_nxt;       // some slot stays armed after this poll
  logic [CW-1:0] cnt_r, cnt_nxt;       // candidates seen in the current scan

  logic [CW-1:0] idx_r, idx_nxt;       // scan read address counter
  logic [AW-1:0] ridx_r, ridx_nxt;     // address of data now on rdata
  logic          rv_r, rv_nxt;
  logic          best_v_r, best_v_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic [63:0]   bestd_r, bestd_nxt;

  logic          ov_r, ov_nxt;
  logic [79:0]   od_r, od_nxt;
  logic          ol_r, ol_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  slot_ent_t     wdata, rdata;

  ott_ram #(.WIDTH($bits(slot_ent_t)), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic ok_slot;
  logic [AW-1:0] s;
  logic cand;
  logic due_c;
  logic [63:0] wtmp;
  logic [63:0] start;

  assign ok_slot = ({28'd0, slot_r} < SLOTS);
  assign s = AW'(slot_r);
  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tlast = ol_r;

  always_comb begin
    state_nxt = state_r; armed_nxt = armed_r; done_nxt = done_r;
    notified_nxt = notified_r; prev_nxt = prev_r;
    kind_nxt = kind_r; slot_nxt = slot_r; per_nxt = per_r; rep_nxt = rep_r;
    fnow_nxt = fnow_r; now_nxt = now_r; jump_nxt = jump_r;
    status_nxt = status_r; fn_nxt = fn_r; chk_nxt = chk_r;
    surv_nxt = surv_r; cnt_nxt = cnt_r;
    idx_nxt = idx_r; ridx_nxt = ridx_r; rv_nxt = 1'b0;
    best_v_nxt = best_v_r; best_nxt = best_r; bestd_nxt = bestd_r;
    ov_nxt = ov_r; od_nxt = od_r; ol_nxt = ol_r;
    we = 1'b0; waddr = s; wdata = rdata; raddr = s;
    cand = 1'b0; due_c = 1'b0; wtmp = '0; start = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          kind_nxt = in_tuser; slot_nxt = in_tdata[3:0];
          per_nxt = in_tdata[35:4]; rep_nxt = in_tdata[36];
          fnow_nxt = in_tdata[37]; now_nxt = in_tdata[101:38];
          status_nxt = ST_NONE; fn_nxt = 1'b0; chk_nxt = 1'b0;
          done_nxt = '0; surv_nxt = 1'b0; cnt_nxt = '0;
          idx_nxt = '0; best_v_nxt = 1'b0;
          case (in_tuser)
            K_ADD, K_CANCEL, K_REFRESH, K_RESET: state_nxt = S_RD;
            K_QUERY: begin
              notified_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            K_POLL: begin
              jump_nxt = (in_tdata[101:38] < prev_r) &&
                         (in_tdata[101:38] < prev_r - 64'(HOUR_MS));
              if (armed_r != '0) prev_nxt = in_tdata[101:38];
              state_nxt = S_SCAN;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_RD: begin
        raddr = s;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        state_nxt = S_OUT;
        if (ok_slot) begin
          case (kind_r)
            K_ADD: begin
              if (armed_r[s]) status_nxt = ST_BUSY;
              else begin
                armed_nxt[s] = 1'b1; we = 1'b1;
                wdata.rearm = rep_r; wdata.interval = per_r;
                wdata.deadline = now_r + {32'd0, per_r};
                status_nxt = ST_OK; chk_nxt = 1'b1;
              end
            end
            K_CANCEL: if (armed_r[s]) begin
              armed_nxt[s] = 1'b0; status_nxt = ST_OK;
            end
            K_REFRESH: if (armed_r[s]) begin
              we = 1'b1; wdata.deadline = now_r + {32'd0, rdata.interval};
              status_nxt = ST_OK;
            end
            K_RESET: if (armed_r[s]) begin
              status_nxt = ST_OK;
              if (per_r != rdata.interval || fnow_r) begin
                start = fnow_r ? now_r : rdata.deadline - {32'd0, rdata.interval};
                we = 1'b1; wdata.interval = per_r;
                wdata.deadline = start + {32'd0, per_r};
                chk_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
        if (chk_nxt) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // issue one read per cycle, compare the slot read in the previous cycle
        if (rv_r) begin
          due_c = jump_r || rdata.deadline <= now_r;
          cand = armed_r[ridx_r] && !done_r[ridx_r];
          if (kind_r == K_POLL) begin
            cand = cand && due_c;
            if (armed_r[ridx_r] && (!due_c || rdata.rearm)) surv_nxt = 1'b1;
          end
          if (cand) cnt_nxt = cnt_r + 1'b1;
          if (cand && (!best_v_r || rdata.deadline < bestd_r)) begin
            best_v_nxt = 1'b1; best_nxt = ridx_r; bestd_nxt = rdata.deadline;
          end
        end
        if (idx_r < CW'(SLOTS)) begin
          raddr = idx_r[AW-1:0]; ridx_nxt = idx_r[AW-1:0]; rv_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else if (!rv_r) state_nxt = S_SCANW;
      end
      S_SCANW: begin
        case (kind_r)
          K_QUERY: state_nxt = S_QOUT;
          K_POLL: state_nxt = S_FIRE;
          default: begin
            if (best_v_r && best_r == s && !notified_r) begin
              fn_nxt = 1'b1; notified_nxt = 1'b1;
            end
            state_nxt = S_OUT;
          end
        endcase
      end
      S_QOUT: begin
        if (!ov_r) begin
          if (!best_v_r) wtmp = ALL_ONES;
          else if (now_r >= bestd_r) wtmp = '0;
          else wtmp = bestd_r - now_r;
          ov_nxt = 1'b1; ol_nxt = 1'b1;
          od_nxt = {7'd0, armed_r != '0, 1'b0, wtmp, 4'd0, 1'b0, ST_OK};
          state_nxt = S_IDLE;
        end
      end
      S_FIRE: begin
        raddr = best_r;
        if (!best_v_r) state_nxt = S_OUT;
        else state_nxt = S_FIREW;
      end
      S_FIREW: begin
        // hold the read address so rdata stays on the fired slot while stalled
        raddr = best_r;
        if (!ov_r) begin
          waddr = best_r; wdata = rdata;
          if (rdata.rearm) begin
            we = 1'b1; wdata.deadline = now_r + {32'd0, rdata.interval};
          end else armed_nxt[best_r] = 1'b0;
          done_nxt[best_r] = 1'b1;
          // the only candidate left in this scan is the last result
          ov_nxt = 1'b1; ol_nxt = (cnt_r == CW'(1));
          od_nxt = {7'd0, surv_r, 1'b0, 64'd0, 4'(best_r), 1'b1, ST_OK};
          idx_nxt = '0; best_v_nxt = 1'b0; cnt_nxt = '0;
          state_nxt = (cnt_r == CW'(1)) ? S_IDLE : S_SCAN;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; ol_nxt = 1'b1;
          od_nxt = {7'd0, armed_r != '0, fn_r, 64'd0, 4'd0, 1'b0, status_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; armed_r <= '0; notified_r <= 1'b0; prev_r <= '0;
      ov_r <= 1'b0; rv_r <= 1'b0;
    end else begin
      state_r <= state_nxt; armed_r <= armed_nxt; notified_r <= notified_nxt;
      prev_r <= prev_nxt; ov_r <= ov_nxt; rv_r <= rv_nxt;
    end
    done_r <= done_nxt; kind_r <= kind_nxt; slot_r <= slot_nxt;
    per_r <= per_nxt; rep_r <= rep_nxt; fnow_r <= fnow_nxt; now_r <= now_nxt;
    jump_r <= jump_nxt; status_r <= status_nxt; fn_r <= fn_nxt; chk_r <= chk_nxt;
    surv_r <= surv_nxt; cnt_r <= cnt_nxt; idx_r <= idx_nxt; ridx_r <= ridx_nxt;
    best_v_r <= best_v_nxt; best_r <= best_nxt; bestd_r <= bestd_nxt;
    od_r <= od_nxt; ol_r <= ol_nxt;
  end

  `OTT_ASSERT_IMPL(a_ready_idle, in_tready, state_r == S_IDLE)
  `OTT_ASSERT_NEXT(a_fire_done, state_r == S_FIREW && !ov_r, done_r[best_r])
  `OTT_ASSERT_IMPL(a_fired_armed, state_r == S_FIREW, best_v_r && armed_r[best_r])
endmodule

[verif/tb_top.sv]
module tb_top;
  import ott_pkg::*;

  localparam int NSLOT = 16;
  localparam longint unsigned LIMIT = 2000000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [79:0]  out_tdata;
  logic         out_tlast;

  ordered_timer_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  typedef struct packed {
    logic [1:0]  status;
    logic        fired_valid;
    logic [3:0]  fired_slot;
    logic [63:0] wait_ms;
    logic        front_notify;
    logic        any_armed;
    logic        last;
  } timer_result_t;

  // timer table mirror
  logic        t_armed [NSLOT];
  logic        t_rearm [NSLOT];
  logic [31:0] t_interval [NSLOT];
  logic [63:0] t_deadline [NSLOT];
  logic        t_notified;
  logic [63:0] t_prev_now;

  timer_result_t expected_results[$];
  int errors = 0;
  int mismatches = 0;
  longint unsigned cycles = 0;
  int send_idle_pct;
  int recv_stall_pct;
  logic [63:0] clock_ms;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic bool_precedes(int a, int b);
    if (t_deadline[a] != t_deadline[b]) return t_deadline[a] < t_deadline[b];
    return a < b;
  endfunction

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++)
      if (t_armed[i] && (best < 0 || bool_precedes(i, best))) best = i;
    return best;
  endfunction

  function automatic logic front_check(int s);
    if (earliest_slot() == s && !t_notified) begin
      t_notified = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_result(logic [1:0] st, logic fv, logic [3:0] fs,
                                      logic [63:0] w, logic fn, logic lst);
    timer_result_t r;
    r.status = st; r.fired_valid = fv; r.fired_slot = fs; r.wait_ms = w;
    r.front_notify = fn; r.any_armed = earliest_slot() >= 0; r.last = lst;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void predict_request(kind_t kind, int s, logic [31:0] period,
                                          logic rep, logic fnow, logic [63:0] now);
    logic [1:0] st;
    logic fn;
    logic [63:0] start;
    int f;
    int best;
    int n;
    logic due [NSLOT];
    int order [NSLOT];
    logic jump;
    st = ST_NONE;
    fn = 1'b0;
    case (kind)
      K_ADD: begin
        if (t_armed[s]) st = ST_BUSY;
        else begin
          t_armed[s] = 1'b1; t_rearm[s] = rep; t_interval[s] = period;
          t_deadline[s] = now + 64'(period);
          fn = front_check(s);
          st = ST_OK;
        end
      end
      K_CANCEL: if (t_armed[s]) begin
        t_armed[s] = 1'b0; st = ST_OK;
      end
      K_REFRESH: if (t_armed[s]) begin
        t_deadline[s] = now + 64'(t_interval[s]); st = ST_OK;
      end
      K_RESET: if (t_armed[s]) begin
        st = ST_OK;
        if (period != t_interval[s] || fnow) begin
          start = fnow ? now : t_deadline[s] - 64'(t_interval[s]);
          t_interval[s] = period;
          t_deadline[s] = start + 64'(period);
          fn = front_check(s);
        end
      end
      K_QUERY: begin
        f = earliest_slot();
        t_notified = 1'b0;
        push_result(ST_OK, 1'b0, 4'd0, f < 0 ? ALL_ONES :
                    (now >= t_deadline[f] ? 64'd0 : t_deadline[f] - now),
                    1'b0, 1'b1);
        return;
      end
      K_POLL: begin
        n = 0;
        if (earliest_slot() >= 0) begin
          jump = now < t_prev_now && now < t_prev_now - 64'(HOUR_MS);
          t_prev_now = now;
          for (int i = 0; i < NSLOT; i++)
            due[i] = t_armed[i] && (jump || t_deadline[i] <= now);
          forever begin
            best = -1;
            for (int i = 0; i < NSLOT; i++)
              if (due[i] && (best < 0 || bool_precedes(i, best))) best = i;
            if (best < 0) break;
            due[best] = 1'b0;
            order[n] = best;
            n++;
          end
          for (int k = 0; k < n; k++)
            if (t_rearm[order[k]])
              t_deadline[order[k]] = now + 64'(t_interval[order[k]]);
            else t_armed[order[k]] = 1'b0;
        end
        if (n == 0) push_result(ST_NONE, 1'b0, 4'd0, 64'd0, 1'b0, 1'b1);
        for (int k = 0; k < n; k++)
          push_result(ST_OK, 1'b1, 4'(order[k]), 64'd0, 1'b0, k == n - 1);
        return;
      end
      default: ;
    endcase
    push_result(st, 1'b0, 4'd0, 64'd0, fn, 1'b1);
  endfunction

  // out_tready policy
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[1:0];
      got.fired_valid = out_tdata[2];
      got.fired_slot = out_tdata[6:3];
      got.wait_ms = out_tdata[70:7];
      got.front_notify = out_tdata[71];
      got.any_armed = out_tdata[72];
      got.last = out_tlast;
      if (expected_results.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result %p", got);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (mismatches < 10) $display("mismatch: expected %p actual %p", exp_r, got);
          mismatches++;
        end
      end
    end
  end

  task automatic send_request(kind_t kind, int s, logic [31:0] period,
                              logic rep, logic fnow, logic [63:0] now);
    // drop valid only for an idle gap, otherwise hold it into the next request
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {2'b0, now, fnow, rep, period, 4'(s)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(kind, s, period, rep, fnow, now);
  endtask

  task automatic test_directed();
    send_request(K_QUERY, 0, 32'd0, 1'b0, 1'b0, 64'd0);
    send_request(K_POLL, 0, 32'd0, 1'b0, 1'b0, 64'd5);
    send_request(K_CANCEL, 3, 32'd0, 1'b0, 1'b0, 64'd5);
    send_request(K_REFRESH, 3, 32'd0, 1'b0, 1'b0, 64'd5);
    send_request(K_RESET, 3, 32'd7, 1'b0, 1'b1, 64'd5);
    send_request(K_ADD, 0, 32'd100, 1'b1, 1'b0, 64'd10);
    send_request(K_ADD, 0, 32'd50, 1'b0, 1'b0, 64'd10);
    send_request(K_ADD, 15, 32'hFFFF_FFFF, 1'b0, 1'b1, 64'd10);
    send_request(K_ADD, 7, 32'd100, 1'b0, 1'b0, 64'd10);
    send_request(K_QUERY, 0, 32'd0, 1'b0, 1'b0, 64'd20);
    send_request(K_ADD, 4, 32'd5, 1'b0, 1'b0, 64'd20);
    send_request(K_RESET, 4, 32'd5, 1'b0, 1'b0, 64'd20);
    send_request(K_RESET, 7, 32'd3, 1'b0, 1'b0, 64'd20);
    send_request(K_REFRESH, 0, 32'd0, 1'b0, 1'b0, 64'd30);
    send_request(K_POLL, 0, 32'd0, 1'b0, 1'b0, 64'd40);
    send_request(K_POLL, 0, 32'd0, 1'b0, 1'b0, 64'd200);
    send_request(kind_t'(3'd6), 1, 32'd0, 1'b0, 1'b0, 64'd200);
    send_request(kind_t'(3'd7), 1, 32'd0, 1'b0, 1'b0, 64'd200);
    send_request(K_ADD, 9, 32'd10, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(K_POLL, 0, 32'd0, 1'b0, 1'b0, 64'd100);
    send_request(K_POLL, 0, 32'd0, 1'b0, 1'b0, 64'd0);
    send_request(K_QUERY, 0, 32'd0, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_random(int items, int idle, int stall);
    kind_t kind;
    int s;
    logic [31:0] period;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(9))
        0, 1, 2: kind = K_ADD;
        3: kind = K_CANCEL;
        4: kind = K_REFRESH;
        5: kind = K_RESET;
        6: kind = K_QUERY;
        default: kind = K_POLL;
      endcase
      s = $urandom_range(NSLOT - 1);
      period = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(300));
      if ($urandom_range(29) == 0)
        clock_ms = {$urandom, $urandom};
      else if ($urandom_range(19) == 0)
        clock_ms = clock_ms - 64'(HOUR_MS) - 64'($urandom_range(2));
      else
        clock_ms = clock_ms + 64'($urandom_range(120));
      send_request(kind, s, period, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   clock_ms);
    end
  endtask

  initial begin
    int drain;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clock_ms = 64'd1000;
    for (int i = 0; i < NSLOT; i++) begin
      t_armed[i] = 0; t_rearm[i] = 0; t_interval[i] = 0; t_deadline[i] = 0;
    end
    t_notified = 0;
    t_prev_now = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(25, 0, 0);
    test_random(25, 63, 0);
    test_random(25, 0, 63);
    test_random(25, 24, 24);
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 400) begin
      @(posedge clk);
      drain++;
    end
    if (errors == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/ott_pkg.sv
rtl/ott_ram.sv
rtl/ordered_timer_table.sv
verif/tb_top.sv
